@@ rtl/lpst_pkg.sv @@
// Shared types, constants and the CRC-8 step for the lidar packet sector tracker.
// No dependencies; the top level imports this package.
package lpst_pkg;

    localparam int PKT_POINTS     = 12;
    localparam int PACKET_BYTES   = 47;
    localparam int PKT_ADDR_W     = $clog2(PACKET_BYTES);
    localparam int SIDE_CENTER_CD = 9000;
    localparam int FULL_TURN      = 36000;
    localparam int HALF_TURN      = 18000;
    localparam int POINT_BASE     = 6;
    localparam int POINT_STRIDE   = 3;

    localparam logic [7:0] HDR_BYTE    = 8'h54;
    localparam logic [7:0] VERLEN_BYTE = 8'h2C;
    localparam logic [7:0] CRC_POLY    = 8'h4D;

    // floor(m / 11) = (m * DIV11_RECIP) >> DIV11_SHIFT for any 16-bit m
    localparam logic [15:0] DIV11_RECIP = 16'd47663;
    localparam int          DIV11_SHIFT = 19;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_PACKET  = 2'd1;
    localparam logic [1:0] EV_CRC     = 2'd2;
    localparam logic [1:0] EV_TIMEOUT = 2'd3;

    localparam logic [2:0] REG_MIN_VALID  = 3'd0;
    localparam logic [2:0] REG_MAX_VALID  = 3'd1;
    localparam logic [2:0] REG_MIN_INTENS = 3'd2;
    localparam logic [2:0] REG_MOUNT      = 3'd3;
    localparam logic [2:0] REG_FC_HALF    = 3'd4;
    localparam logic [2:0] REG_FS_HALF    = 3'd5;
    localparam logic [2:0] REG_SIDE_HALF  = 3'd6;
    localparam logic [2:0] REG_TIMEOUT    = 3'd7;

    localparam int SEC_FL = 0;
    localparam int SEC_FC = 1;
    localparam int SEC_FR = 2;
    localparam int SEC_SL = 3;
    localparam int SEC_SR = 4;
    localparam int SECTORS = 5;

    typedef struct packed {
        logic        mode;
        logic [7:0]  data_byte;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  event_code;
        logic        scan_done;
        logic        obstacle_valid;
        logic [15:0] fl_near;
        logic [15:0] fc_near;
        logic [15:0] fr_near;
        logic [15:0] sl_near;
        logic [15:0] sr_near;
        logic [15:0] speed_dps;
        logic [15:0] good_pkts;
        logic [15:0] crc_fails;
        logic [15:0] scans_pub;
    } out_item_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

@@ rtl/lpst_stream_if.sv @@
// Valid/ready stream channel carrying one payload beat.
// Payload type is supplied by the instantiating level from lpst_pkg.
interface lpst_stream_if #(parameter type item_t = logic);
    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/lpst_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lpst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 47
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/lidar_packet_sector_tracker.sv @@
// Top level of the lidar packet sector tracker: framing, CRC, point walk, sectors.
// Depends on lpst_pkg, lpst_stream_if and lpst_ram.
//
//   channel  dir  beat contents
//   in_ch    in   mode, data_byte, now_ms
//   out_ch   out  event_code, scan_done, obstacle_valid, five sectors, speed, counters
//   apb      in   eight registers at 4*index, write on psel&penable&pwrite
//
// A tick or an ordinary byte goes from accept to S_DONE, then into the output register.
// The byte closing a good packet walks S_PARSE, S_MUL, S_DIV, then per point S_RD_LO,
// S_RD_HI, S_RD_INT, S_ROT, S_FOLD, paced by the single RAM read port and one angle/fold unit.
// in_ch.ready is high only in the idle state; a pending result in the output register
// does not block acceptance, only the final hand-over.
// Reset is asynchronous; the packet RAM needs no clearing pass.
module lidar_packet_sector_tracker (
    input  logic        clk,
    input  logic        rst_n,
    lpst_stream_if.sink   in_ch,
    lpst_stream_if.source out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lpst_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_PARSE  = 10'b0000000010,
        S_MUL    = 10'b0000000100,
        S_DIV    = 10'b0000001000,
        S_RD_LO  = 10'b0000010000,
        S_RD_HI  = 10'b0000100000,
        S_RD_INT = 10'b0001000000,
        S_ROT    = 10'b0010000000,
        S_FOLD   = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] min_valid_reg, max_valid_reg, mount_reg;
    logic [7:0]  min_int_reg;
    logic [14:0] fc_half_reg, fs_half_reg, side_half_reg;
    logic [31:0] timeout_reg;

    logic [PKT_ADDR_W-1:0] pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] spd_reg, spd_next, start_reg, start_next, end_reg, end_next;
    logic [31:0] now_reg, now_next;
    logic [1:0]  ev_reg, ev_next;
    logic        done_reg, done_next;

    logic        have_prev_reg, have_prev_next;
    logic [15:0] prev_start_reg, prev_start_next;
    logic [15:0] run_min_reg [SECTORS];
    logic [15:0] run_min_next [SECTORS];
    logic [15:0] snap_reg [SECTORS];
    logic [15:0] snap_next [SECTORS];
    logic        snap_valid_reg, snap_valid_next;
    logic [31:0] snap_time_reg, snap_time_next;
    logic [15:0] last_speed_reg, last_speed_next;
    logic [15:0] pkt_cnt_reg, pkt_cnt_next, crc_err_reg, crc_err_next;
    logic [15:0] scan_cnt_reg, scan_cnt_next;

    logic        span_neg_reg, span_neg_next;
    logic [15:0] span_mag_reg, span_mag_next;
    logic [31:0] prod_reg, prod_next;
    logic [12:0] quo_reg, quo_next;
    logic [3:0]  rem_b_reg, rem_b_next, acc_r_reg, acc_r_next;
    logic [15:0] ang_reg, ang_next, off_mod_reg, off_mod_next;
    logic [3:0]  pt_reg, pt_next;
    logic [PKT_ADDR_W-1:0] base_reg, base_next;
    logic [7:0]  lo_reg, lo_next, hi_reg, hi_next;
    logic        pass_reg, pass_next, left_reg, left_next;
    logic [14:0] mag_reg, mag_next;
    logic [15:0] dist_reg, dist_next;

    out_item_t   out_reg, out_next;
    logic        out_valid_reg, out_valid_next;

    logic                  ram_we;
    logic [PKT_ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]            ram_wdata, ram_rdata;

    lpst_ram #(.WIDTH(8), .DEPTH(PACKET_BYTES)) u_pkt_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // configuration port
    logic       cfg_we;
    logic [2:0] cfg_idx;
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_valid_reg <= 16'd20;
            max_valid_reg <= 16'd12000;
            min_int_reg   <= 8'd10;
            mount_reg     <= 16'd0;
            fc_half_reg   <= 15'd1500;
            fs_half_reg   <= 15'd4500;
            side_half_reg <= 15'd3000;
            timeout_reg   <= 32'd500;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_MIN_VALID:  min_valid_reg <= pwdata[15:0];
                REG_MAX_VALID:  max_valid_reg <= pwdata[15:0];
                REG_MIN_INTENS: min_int_reg   <= pwdata[7:0];
                REG_MOUNT:      mount_reg     <= pwdata[15:0];
                REG_FC_HALF:    fc_half_reg   <= pwdata[14:0];
                REG_FS_HALF:    fs_half_reg   <= pwdata[14:0];
                REG_SIDE_HALF:  side_half_reg <= pwdata[14:0];
                REG_TIMEOUT:    timeout_reg   <= pwdata;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_MIN_VALID:  prdata = {16'd0, min_valid_reg};
            REG_MAX_VALID:  prdata = {16'd0, max_valid_reg};
            REG_MIN_INTENS: prdata = {24'd0, min_int_reg};
            REG_MOUNT:      prdata = {16'd0, mount_reg};
            REG_FC_HALF:    prdata = {17'd0, fc_half_reg};
            REG_FS_HALF:    prdata = {17'd0, fs_half_reg};
            REG_SIDE_HALF:  prdata = {17'd0, side_half_reg};
            REG_TIMEOUT:    prdata = timeout_reg;
            default:        prdata = 32'd0;
        endcase
    end

    assign in_ch.ready    = (state_reg == S_IDLE);
    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_reg;

    in_item_t    in_item;
    logic        accept;
    logic [31:0] age;
    logic [16:0] span_raw, span_fix, start_x, off_x;
    logic [16:0] quo_x11;
    logic [16:0] rot_diff, rot_w;
    logic [15:0] dist_w, side_d;
    logic [4:0]  r_sum;
    logic        r_carry;
    logic [13:0] delta;
    logic [16:0] ang_step;
    logic        hit_fc, hit_fs;

    assign in_item = in_ch.payload;
    assign accept  = in_ch.valid && in_ch.ready;
    assign age     = in_item.now_ms - snap_time_reg;

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        crc_next        = crc_reg;
        spd_next        = spd_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        now_next        = now_reg;
        ev_next         = ev_reg;
        done_next       = done_reg;
        have_prev_next  = have_prev_reg;
        prev_start_next = prev_start_reg;
        run_min_next    = run_min_reg;
        snap_next       = snap_reg;
        snap_valid_next = snap_valid_reg;
        snap_time_next  = snap_time_reg;
        last_speed_next = last_speed_reg;
        pkt_cnt_next    = pkt_cnt_reg;
        crc_err_next    = crc_err_reg;
        scan_cnt_next   = scan_cnt_reg;
        span_neg_next   = span_neg_reg;
        span_mag_next   = span_mag_reg;
        prod_next       = prod_reg;
        quo_next        = quo_reg;
        rem_b_next      = rem_b_reg;
        acc_r_next      = acc_r_reg;
        ang_next        = ang_reg;
        off_mod_next    = off_mod_reg;
        pt_next         = pt_reg;
        base_next       = base_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        pass_next       = pass_reg;
        left_next       = left_reg;
        mag_next        = mag_reg;
        dist_next       = dist_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;

        ram_we    = 1'b0;
        ram_waddr = pos_reg;
        ram_wdata = in_item.data_byte;
        ram_raddr = base_reg;

        span_raw = {1'b0, end_reg} - {1'b0, start_reg};
        span_fix = span_raw[16] ? span_raw + 17'(FULL_TURN) : span_raw;
        start_x  = {1'b0, start_reg} - 17'(FULL_TURN);
        off_x    = {1'b0, mount_reg} - 17'(FULL_TURN);
        quo_x11  = {1'b0, quo_reg, 3'b0} + {3'b0, quo_reg, 1'b0} + {4'b0, quo_reg};

        dist_w   = {hi_reg, lo_reg};
        rot_diff = {1'b0, ang_reg} - {1'b0, off_mod_reg};
        rot_w    = rot_diff[16] ? rot_diff + 17'(FULL_TURN) : rot_diff;

        hit_fc = (mag_reg <= fc_half_reg);
        hit_fs = !hit_fc && (mag_reg <= fs_half_reg);
        side_d = (mag_reg >= 15'(SIDE_CENTER_CD)) ? {1'b0, mag_reg - 15'(SIDE_CENTER_CD)}
                                                  : {1'b0, 15'(SIDE_CENTER_CD) - mag_reg};
        if (side_d > 16'(HALF_TURN))
        begin
            side_d = 16'(FULL_TURN) - side_d;
        end

        r_sum   = {1'b0, acc_r_reg} + {1'b0, rem_b_reg};
        r_carry = (r_sum >= 5'd11);
        delta   = {1'b0, quo_reg} + {13'd0, r_carry};
        if (!span_neg_reg)
        begin
            ang_step = {1'b0, ang_reg} + {3'b0, delta};
            if (ang_step >= 17'(FULL_TURN))
            begin
                ang_step = ang_step - 17'(FULL_TURN);
            end
        end
        else
        begin
            ang_step = {1'b0, ang_reg} - {3'b0, delta};
            if (ang_step[16])
            begin
                ang_step = ang_step + 17'(FULL_TURN);
            end
        end

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ev_next    = EV_NONE;
                    done_next  = 1'b0;
                    now_next   = in_item.now_ms;
                    state_next = S_DONE;
                    if (in_item.mode)
                    begin
                        if (snap_valid_reg && (age > timeout_reg))
                        begin
                            snap_valid_next = 1'b0;
                            have_prev_next  = 1'b0;
                            for (int s = 0; s < SECTORS; s++)
                            begin
                                run_min_next[s] = max_valid_reg;
                            end
                            ev_next = EV_TIMEOUT;
                        end
                    end
                    else if (pos_reg == '0)
                    begin
                        if (in_item.data_byte == HDR_BYTE)
                        begin
                            ram_we   = 1'b1;
                            pos_next = PKT_ADDR_W'(1);
                            crc_next = crc8_update(8'd0, in_item.data_byte);
                        end
                    end
                    else if (pos_reg == PKT_ADDR_W'(1) && in_item.data_byte != VERLEN_BYTE)
                    begin
                        // resync: a fresh header restarts the frame
                        if (in_item.data_byte == HDR_BYTE)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = '0;
                            pos_next  = PKT_ADDR_W'(1);
                            crc_next  = crc8_update(8'd0, in_item.data_byte);
                        end
                        else
                        begin
                            pos_next = '0;
                        end
                    end
                    else if (pos_reg == PKT_ADDR_W'(PACKET_BYTES - 1))
                    begin
                        pos_next = '0;
                        if (crc_reg == in_item.data_byte)
                        begin
                            ev_next    = EV_PACKET;
                            state_next = S_PARSE;
                        end
                        else
                        begin
                            crc_err_next = crc_err_reg + 16'd1;
                            ev_next      = EV_CRC;
                        end
                    end
                    else
                    begin
                        ram_we   = 1'b1;
                        pos_next = pos_reg + PKT_ADDR_W'(1);
                        crc_next = crc8_update(crc_reg, in_item.data_byte);
                        unique case (pos_reg)
                            PKT_ADDR_W'(2):  spd_next[7:0]    = in_item.data_byte;
                            PKT_ADDR_W'(3):  spd_next[15:8]   = in_item.data_byte;
                            PKT_ADDR_W'(4):  start_next[7:0]  = in_item.data_byte;
                            PKT_ADDR_W'(5):  start_next[15:8] = in_item.data_byte;
                            PKT_ADDR_W'(42): end_next[7:0]    = in_item.data_byte;
                            PKT_ADDR_W'(43): end_next[15:8]   = in_item.data_byte;
                            default:         ;
                        endcase
                    end
                end
            end

            S_PARSE:
            begin
                pkt_cnt_next    = pkt_cnt_reg + 16'd1;
                last_speed_next = spd_reg;
                if (have_prev_reg && (start_reg < prev_start_reg))
                begin
                    snap_valid_next = 1'b1;
                    snap_time_next  = now_reg;
                    snap_next       = run_min_reg;
                    scan_cnt_next   = scan_cnt_reg + 16'd1;
                    for (int s = 0; s < SECTORS; s++)
                    begin
                        run_min_next[s] = max_valid_reg;
                    end
                    done_next = 1'b1;
                end
                have_prev_next  = 1'b1;
                prev_start_next = start_reg;
                span_neg_next   = span_fix[16];
                span_mag_next   = span_fix[16] ? 16'(-span_fix) : span_fix[15:0];
                ang_next        = start_x[16] ? start_reg : start_x[15:0];
                off_mod_next    = off_x[16] ? mount_reg : off_x[15:0];
                state_next      = S_MUL;
            end

            S_MUL:
            begin
                prod_next  = span_mag_reg * DIV11_RECIP;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                quo_next   = prod_reg[31:DIV11_SHIFT];
                state_next = S_RD_LO;
                pt_next    = '0;
                base_next  = PKT_ADDR_W'(POINT_BASE);
                acc_r_next = '0;
            end

            S_RD_LO:
            begin
                // remainder of the span by 11, now that the quotient is registered
                if (pt_reg == '0)
                begin
                    rem_b_next = 4'({1'b0, span_mag_reg} - quo_x11);
                end
                ram_raddr  = base_reg;
                state_next = S_RD_HI;
            end

            S_RD_HI:
            begin
                ram_raddr  = base_reg + PKT_ADDR_W'(1);
                lo_next    = ram_rdata;
                state_next = S_RD_INT;
            end

            S_RD_INT:
            begin
                ram_raddr  = base_reg + PKT_ADDR_W'(2);
                hi_next    = ram_rdata;
                state_next = S_ROT;
            end

            S_ROT:
            begin
                dist_next = dist_w;
                pass_next = (dist_w >= min_valid_reg) && (dist_w <= max_valid_reg)
                            && (ram_rdata >= min_int_reg);
                if (rot_w > 17'(HALF_TURN))
                begin
                    mag_next  = 15'(17'(FULL_TURN) - rot_w);
                    left_next = 1'b0;
                end
                else
                begin
                    mag_next  = rot_w[14:0];
                    left_next = (rot_w != '0);
                end
                state_next = S_FOLD;
            end

            S_FOLD:
            begin
                if (pass_reg)
                begin
                    if (hit_fc && dist_reg < run_min_reg[SEC_FC])
                    begin
                        run_min_next[SEC_FC] = dist_reg;
                    end
                    if (hit_fs && left_reg && dist_reg < run_min_reg[SEC_FL])
                    begin
                        run_min_next[SEC_FL] = dist_reg;
                    end
                    if (hit_fs && !left_reg && dist_reg < run_min_reg[SEC_FR])
                    begin
                        run_min_next[SEC_FR] = dist_reg;
                    end
                    if (side_d <= {1'b0, side_half_reg})
                    begin
                        if (left_reg && dist_reg < run_min_reg[SEC_SL])
                        begin
                            run_min_next[SEC_SL] = dist_reg;
                        end
                        if (!left_reg && dist_reg < run_min_reg[SEC_SR])
                        begin
                            run_min_next[SEC_SR] = dist_reg;
                        end
                    end
                end
                acc_r_next = r_carry ? 4'(r_sum - 5'd11) : r_sum[3:0];
                ang_next   = ang_step[15:0];
                pt_next    = pt_reg + 4'd1;
                base_next  = base_reg + PKT_ADDR_W'(POINT_STRIDE);
                state_next = (pt_reg == 4'(PKT_POINTS - 1)) ? S_DONE : S_RD_LO;
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_next.event_code     = ev_reg;
                    out_next.scan_done      = done_reg;
                    out_next.obstacle_valid = snap_valid_reg;
                    out_next.fl_near        = snap_reg[SEC_FL];
                    out_next.fc_near        = snap_reg[SEC_FC];
                    out_next.fr_near        = snap_reg[SEC_FR];
                    out_next.sl_near        = snap_reg[SEC_SL];
                    out_next.sr_near        = snap_reg[SEC_SR];
                    out_next.speed_dps      = last_speed_reg;
                    out_next.good_pkts      = pkt_cnt_reg;
                    out_next.crc_fails      = crc_err_reg;
                    out_next.scans_pub      = scan_cnt_reg;
                    out_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pos_reg        <= '0;
            crc_reg        <= '0;
            have_prev_reg  <= 1'b0;
            prev_start_reg <= '0;
            for (int s = 0; s < SECTORS; s++)
            begin
                run_min_reg[s] <= 16'd12000;
                snap_reg[s]    <= '0;
            end
            snap_valid_reg <= 1'b0;
            snap_time_reg  <= '0;
            last_speed_reg <= '0;
            pkt_cnt_reg    <= '0;
            crc_err_reg    <= '0;
            scan_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
            pt_reg         <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            crc_reg        <= crc_next;
            have_prev_reg  <= have_prev_next;
            prev_start_reg <= prev_start_next;
            run_min_reg    <= run_min_next;
            snap_reg       <= snap_next;
            snap_valid_reg <= snap_valid_next;
            snap_time_reg  <= snap_time_next;
            last_speed_reg <= last_speed_next;
            pkt_cnt_reg    <= pkt_cnt_next;
            crc_err_reg    <= crc_err_next;
            scan_cnt_reg   <= scan_cnt_next;
            out_valid_reg  <= out_valid_next;
            pt_reg         <= pt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        spd_reg      <= spd_next;
        start_reg    <= start_next;
        end_reg      <= end_next;
        now_reg      <= now_next;
        ev_reg       <= ev_next;
        done_reg     <= done_next;
        span_neg_reg <= span_neg_next;
        span_mag_reg <= span_mag_next;
        prod_reg     <= prod_next;
        quo_reg      <= quo_next;
        rem_b_reg    <= rem_b_next;
        acc_r_reg    <= acc_r_next;
        ang_reg      <= ang_next;
        off_mod_reg  <= off_mod_next;
        base_reg     <= base_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        pass_reg     <= pass_next;
        left_reg     <= left_next;
        mag_reg      <= mag_next;
        dist_reg     <= dist_next;
        out_reg      <= out_next;
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready)
        else $error("input accepted twice in a row");

    a_scan_on_packet: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.payload.scan_done |-> out_ch.payload.event_code == EV_PACKET)
        else $error("scan published without a good packet");

    a_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == S_IDLE)
        else $error("packet RAM written outside byte accept");

    a_point_range: assert property (@(posedge clk) disable iff (!rst_n)
        pt_reg <= 4'(PKT_POINTS - 1) || state_reg == S_DONE || state_reg == S_IDLE
        || state_reg == S_PARSE || state_reg == S_MUL || state_reg == S_DIV)
        else $error("point index past the packet");

endmodule
